// ----- hdl/mssd_pkg.sv -----
// shared types, codes and digit helpers for the seven-segment mode display
package mssd_pkg;

  localparam int AddrWidth = 5;

  localparam logic [2:0] MODE_RAMP  = 3'd1;
  localparam logic [2:0] MODE_FIXED = 3'd2;
  localparam logic [2:0] MODE_VOLT  = 3'd3;
  localparam logic [2:0] MODE_TIME  = 3'd4;

  localparam logic [2:0] REG_RAMP_STEP     = 3'd0;
  localparam logic [2:0] REG_RAMP_TOP      = 3'd1;
  localparam logic [2:0] REG_RAMP_INTERVAL = 3'd2;
  localparam logic [2:0] REG_SCAN_FAST     = 3'd3;
  localparam logic [2:0] REG_SCAN_SLOW     = 3'd4;

  localparam logic [11:0] MvScale    = 12'd3300;
  localparam logic [11:0] Recip10    = 12'd3277;
  localparam logic [11:0] Recip100   = 12'd1311;
  localparam logic [13:0] Recip1000  = 14'd8389;
  localparam logic [7:0]  Recip10Lo  = 8'd205;
  localparam logic [3:0]  Ten        = 4'd10;

  typedef logic [3:0] digit_t;
  typedef digit_t [3:0] digits_t;

  typedef struct packed {
    logic [5:0]  ramp_step;
    logic [11:0] ramp_top;
    logic [9:0]  ramp_interval;
    logic [15:0] scan_hold_fast;
    logic [15:0] scan_hold_slow;
  } cfg_t;

  typedef struct packed {
    logic        button_level;
    logic [11:0] millivolts;
    digits_t     clock_digits;
  } prep_t;

  // four decimal digits of a value below 4096, by reciprocal multiplication
  function automatic digits_t dec_digits(input logic [11:0] v);
    logic [23:0] p1;
    logic [23:0] p2;
    logic [25:0] p3;
    logic [16:0] p11;
    logic [13:0] p21;
    logic [8:0]  q1;
    logic [6:0]  q2;
    logic [2:0]  q3;
    logic [5:0]  q11;
    logic [2:0]  q21;
    logic [11:0] r0;
    logic [8:0]  r1;
    logic [6:0]  r2;
    digits_t     d;
    p1  = 24'(v) * 24'(Recip10);
    q1  = p1[23:15];
    p2  = 24'(v) * 24'(Recip100);
    q2  = p2[23:17];
    p3  = 26'(v) * 26'(Recip1000);
    q3  = p3[25:23];
    p11 = 17'(q1) * 17'(Recip10Lo);
    q11 = p11[16:11];
    p21 = 14'(q2) * 14'(Recip10Lo);
    q21 = p21[13:11];
    r0  = v - 12'(q1) * 12'(Ten);
    r1  = q1 - 9'(q11) * 9'(Ten);
    r2  = q2 - 7'(q21) * 7'(Ten);
    d[0] = r0[3:0];
    d[1] = r1[3:0];
    d[2] = r2[3:0];
    d[3] = {1'b0, q3};
    return d;
  endfunction

  // segment levels, a in bit 6 down to g in bit 0
  function automatic logic [6:0] seg_pattern(input digit_t d);
    logic [6:0] s;
    unique case (d)
      4'd0: s = 7'h7e;
      4'd1: s = 7'h30;
      4'd2: s = 7'h6d;
      4'd3: s = 7'h79;
      4'd4: s = 7'h33;
      4'd5: s = 7'h5b;
      4'd6: s = 7'h1f;
      4'd7: s = 7'h70;
      4'd8: s = 7'h7f;
      4'd9: s = 7'h73;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/mssd_in_if.sv -----
// input channel: one tick with button, adc sample and clock time
interface mssd_in_if;
  logic        valid;
  logic        ready;
  logic        button_level;
  logic [11:0] adc_sample;
  logic [4:0]  hour;
  logic [5:0]  minute;

  modport source (output valid, output button_level, output adc_sample, output hour,
                  output minute, input ready);
  modport sink (input valid, input button_level, input adc_sample, input hour,
                input minute, output ready);
endinterface

// ----- hdl/mssd_out_if.sv -----
// output channel: display drive, pwm compare and mode after each tick
interface mssd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  digit_select;
  logic [6:0]  segments;
  logic [11:0] pwm_compare;
  logic [2:0]  display_mode;

  modport source (output valid, output digit_select, output segments, output pwm_compare,
                  output display_mode, input ready);
  modport sink (input valid, input digit_select, input segments, input pwm_compare,
                input display_mode, output ready);
endinterface

// ----- hdl/mssd_regs.sv -----
// apb configuration registers
module mssd_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mssd_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output mssd_pkg::cfg_t                 cfg
);
  import mssd_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[AddrWidth-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_step      <= 6'd5;
      cfg.ramp_top       <= 12'd1000;
      cfg.ramp_interval  <= 10'd24;
      cfg.scan_hold_fast <= 16'd1;
      cfg.scan_hold_slow <= 16'd1000;
    end else if (wr) begin
      unique case (idx)
        REG_RAMP_STEP:     cfg.ramp_step      <= pwdata[5:0];
        REG_RAMP_TOP:      cfg.ramp_top       <= pwdata[11:0];
        REG_RAMP_INTERVAL: cfg.ramp_interval  <= pwdata[9:0];
        REG_SCAN_FAST:     cfg.scan_hold_fast <= pwdata[15:0];
        REG_SCAN_SLOW:     cfg.scan_hold_slow <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RAMP_STEP:     prdata = 32'(cfg.ramp_step);
      REG_RAMP_TOP:      prdata = 32'(cfg.ramp_top);
      REG_RAMP_INTERVAL: prdata = 32'(cfg.ramp_interval);
      REG_SCAN_FAST:     prdata = 32'(cfg.scan_hold_fast);
      REG_SCAN_SLOW:     prdata = 32'(cfg.scan_hold_slow);
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ----- hdl/mssd_prep.sv -----
// input register stage: millivolt scaling and clock digit split
module mssd_prep (
  input  logic            clk,
  input  logic            rst,
  mssd_in_if.sink         in_item,
  input  logic            out_free,
  output logic            stage_valid,
  output mssd_pkg::prep_t stage
);
  import mssd_pkg::*;

  logic        take;
  logic [23:0] mv_prod;
  digits_t     hour_dig;
  digits_t     min_dig;
  prep_t       stage_next;

  assign in_item.ready = !stage_valid || out_free;
  assign take          = in_item.valid && in_item.ready;

  always_comb begin
    mv_prod  = 24'(in_item.adc_sample) * 24'(MvScale);
    hour_dig = dec_digits(12'(in_item.hour));
    min_dig  = dec_digits(12'(in_item.minute));
    stage_next.button_level    = in_item.button_level;
    stage_next.millivolts      = mv_prod[23:12];
    stage_next.clock_digits[0] = min_dig[0];
    stage_next.clock_digits[1] = min_dig[1];
    stage_next.clock_digits[2] = hour_dig[0];
    stage_next.clock_digits[3] = hour_dig[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_item.ready) begin
      stage_valid <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= stage_next;
    end
  end

endmodule

// ----- hdl/mssd_core.sv -----
// tick state update: timers, button, pwm ramp, digit scan and result register
module mssd_core (
  input  logic            clk,
  input  logic            rst,
  input  mssd_pkg::cfg_t  cfg,
  input  logic            stage_valid,
  input  mssd_pkg::prep_t stage,
  output logic            out_free,
  mssd_out_if.source      out_item
);
  import mssd_pkg::*;

  logic        take;
  logic        out_valid;
  logic [2:0]  mode;
  logic        key_held;
  logic [15:0] scan_timer;
  logic [1:0]  digit_index;
  logic [9:0]  ramp_timer;
  logic [11:0] ramp_count;
  logic        ramp_rising;
  logic [3:0]  select_latch;
  logic [6:0]  segment_latch;

  logic [2:0]  mode_next;
  logic        key_held_next;
  logic [15:0] scan_timer_next;
  logic [1:0]  digit_index_next;
  logic [9:0]  ramp_timer_next;
  logic [11:0] ramp_count_next;
  logic        ramp_rising_next;
  logic [3:0]  select_latch_next;
  logic [6:0]  segment_latch_next;

  logic [15:0] scan_dec;
  logic [9:0]  ramp_dec;
  logic [12:0] ramp_sum;
  digits_t     ramp_dig;
  digits_t     mv_dig;
  digit_t      shown;

  assign out_free = !out_valid || out_item.ready;
  assign take     = stage_valid && out_free;

  always_comb begin
    scan_dec = (scan_timer != 16'd0) ? scan_timer - 16'd1 : 16'd0;
    ramp_dec = (ramp_timer != 10'd0) ? ramp_timer - 10'd1 : 10'd0;

    // press then release advances the mode
    mode_next     = mode;
    key_held_next = key_held;
    if (!key_held) begin
      if (!stage.button_level) begin
        key_held_next = 1'b1;
      end
    end else if (stage.button_level) begin
      mode_next     = (mode >= MODE_TIME) ? MODE_RAMP : mode + 3'd1;
      key_held_next = 1'b0;
    end

    // triangle ramp
    ramp_sum         = {1'b0, ramp_count} + 13'(cfg.ramp_step);
    ramp_timer_next  = ramp_dec;
    ramp_count_next  = ramp_count;
    ramp_rising_next = ramp_rising;
    if (ramp_dec == 10'd0) begin
      ramp_timer_next = cfg.ramp_interval;
      if (ramp_rising) begin
        ramp_rising_next = !(ramp_count >= cfg.ramp_top);
        if (ramp_count > cfg.ramp_top) begin
          ramp_count_next = 12'd0;
        end else begin
          ramp_count_next = ramp_sum[12] ? 12'hfff : ramp_sum[11:0];
        end
      end else begin
        ramp_rising_next = (ramp_count == 12'd0);
        ramp_count_next  = (ramp_count > 12'(cfg.ramp_step)) ?
                           ramp_count - 12'(cfg.ramp_step) : 12'd0;
      end
    end

    // digit scan
    ramp_dig = dec_digits(ramp_count_next);
    mv_dig   = dec_digits(stage.millivolts);
    unique case (mode_next)
      MODE_FIXED: shown = 4'(digit_index);
      MODE_VOLT:  shown = mv_dig[digit_index];
      MODE_TIME:  shown = stage.clock_digits[digit_index];
      default:    shown = ramp_dig[digit_index];
    endcase

    scan_timer_next    = scan_dec;
    digit_index_next   = digit_index;
    select_latch_next  = select_latch;
    segment_latch_next = segment_latch;
    if (scan_dec == 16'd0) begin
      scan_timer_next    = (mode_next == MODE_FIXED) ? cfg.scan_hold_slow
                                                     : cfg.scan_hold_fast;
      segment_latch_next = seg_pattern(shown);
      select_latch_next  = ~(4'd1 << digit_index);
      digit_index_next   = digit_index + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      mode          <= MODE_RAMP;
      key_held      <= 1'b0;
      scan_timer    <= 16'd0;
      digit_index   <= 2'd0;
      ramp_timer    <= 10'd0;
      ramp_count    <= 12'd0;
      ramp_rising   <= 1'b1;
      select_latch  <= 4'd0;
      segment_latch <= 7'd0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_item.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        mode          <= mode_next;
        key_held      <= key_held_next;
        scan_timer    <= scan_timer_next;
        digit_index   <= digit_index_next;
        ramp_timer    <= ramp_timer_next;
        ramp_count    <= ramp_count_next;
        ramp_rising   <= ramp_rising_next;
        select_latch  <= select_latch_next;
        segment_latch <= segment_latch_next;
      end
    end
  end

  assign out_item.valid        = out_valid;
  assign out_item.digit_select = select_latch;
  assign out_item.segments     = segment_latch;
  assign out_item.pwm_compare  = ramp_count;
  assign out_item.display_mode = mode;

endmodule

// ----- hdl/multiplexed_seven_segment_mode_display.sv -----
// top level of the multiplexed seven-segment mode display
// Takes one tick transaction per clock cycle while the output side is ready and returns
// one result transaction per tick from the second register stage: the first
// register stage scales the adc sample to millivolts with a 12 x 12 multiplier and
// splits hour and minute into digits, the second stage updates the timers, button
// phase, pwm ramp and digit scan and holds the result. A stalled result keeps its
// value while one more transaction can still enter the first stage. Configuration
// registers sit on the apb port at byte address 4 * index and should be written
// only while no transaction is in flight.
module multiplexed_seven_segment_mode_display (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mssd_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  mssd_in_if.sink                        in_item,
  mssd_out_if.source                     out_item
);
  import mssd_pkg::*;

  cfg_t  cfg;
  prep_t stage;
  logic  stage_valid;
  logic  out_free;

  mssd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mssd_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_item     (in_item),
    .out_free    (out_free),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  mssd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stage_valid (stage_valid),
    .stage       (stage),
    .out_free    (out_free),
    .out_item    (out_item)
  );

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> (out_item.display_mode == MODE_RAMP ||
                        out_item.display_mode == MODE_FIXED ||
                        out_item.display_mode == MODE_VOLT ||
                        out_item.display_mode == MODE_TIME))
    else $error("display mode out of range");

  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> (out_item.digit_select == 4'h0 || $onehot(~out_item.digit_select)))
    else $error("more than one digit selected");

  a_mode_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && out_item.display_mode != $past(out_item.display_mode)) |->
      (out_item.display_mode == $past(out_item.display_mode) + 3'd1 ||
       ($past(out_item.display_mode) == MODE_TIME && out_item.display_mode == MODE_RAMP)))
    else $error("display mode skipped a step");

endmodule
